// File: hdl/assert_macros.svh
// Assertion helper macros; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: hdl/puf_pkg.sv
// ---------------------------------------------------------------------------
// puf_pkg
// Shared types and constants for the persistent union-find block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package puf_pkg;
    localparam int unsigned NODE_W = 10;
    localparam int unsigned TIME_W = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        OP_UNITE    = 2'd0,
        OP_ROOT     = 2'd1,
        OP_EARLIEST = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [TIME_W-1:0] at_time;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] value;
        logic              found;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_WT_A,
        ST_RD_B,
        ST_WT_B,
        ST_UNITE_SZ,
        ST_UNITE_SZW,
        ST_UNITE_WR,
        ST_DEPTH,
        ST_DEPTH_W,
        ST_WALK,
        ST_WALK_W,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

// File: hdl/persistent_union_find.sv
// ---------------------------------------------------------------------------
// persistent_union_find
// Partially persistent disjoint-set forest, union by size, stamped links.
// ---------------------------------------------------------------------------
// Channels: in_valid/in_ready carries one request (unite, root at time,
// earliest connection time); out_valid/out_ready carries one result per
// request. Node indexes are reduced modulo NODES.
// All node state sits in one synchronous memory (parent, size, stamp per
// entry) with one read port; every chain step issues an address, then
// uses the registered data. A find takes one chain step per link; depth is
// at most log2(NODES) under union by size. Unite: two finds, then, unless
// the roots match, a root size read and two writes. Earliest-time: two
// finds, two depth walks, then a paired walk up both chains.
// After reset a clearing pass writes every entry before the
// first request is taken. Results sit in an output register; while the
// receiver stalls the block holds the result and takes no new request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module persistent_union_find #(
    parameter int unsigned NODES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire puf_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output puf_pkg::out_item_t      out_data
);
    import puf_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned SW = AW + 1;
    localparam int unsigned DW = AW + 1;
    localparam int unsigned RSH = 24;
    localparam logic [RSH-1:0] RECIP = RSH'((2 ** RSH + NODES - 1) / NODES);

    typedef struct packed {
        logic [AW-1:0]     par;
        logic [SW-1:0]     size;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    entry_t mem [NODES];
    entry_t rd_q;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [AW:0]       clr_reg, clr_next;
    op_t               op_reg, op_next;
    logic [AW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     ra_reg, ra_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] ans_reg, ans_next;
    logic [DW-1:0]     da_reg, da_next, db_reg, db_next, cnt_reg, cnt_next;
    logic              side_reg, side_next;   // 0: walking a, 1: walking b
    logic              phase_reg, phase_next; // 0: find roots, 1: depths
    logic [SW-1:0]     sza_reg, sza_next;
    logic              ov_reg, ov_next;
    out_item_t         od_reg, od_next;
    logic [TIME_W-1:0] stamp_a_reg, stamp_a_next;
    logic [AW-1:0]     par_a_reg, par_a_next;

    // modulo NODES by reciprocal multiply; exact for node fields below 2**RSH / NODES
    function automatic logic [AW-1:0] nidx(input logic [NODE_W-1:0] v);
        logic [NODE_W+RSH-1:0] prod;
        logic [NODE_W-1:0]     quo;
        logic [31:0]           rem;
        prod = (NODE_W+RSH)'(v) * (NODE_W+RSH)'(RECIP);
        quo  = prod[RSH +: NODE_W];
        rem  = 32'(v) - 32'(quo) * 32'(NODES);
        if (NODES >= (2 ** NODE_W))
            rem = 32'(v);
        return rem[AW-1:0];
    endfunction

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            now_reg   <= now_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; a_reg <= a_next; b_reg <= b_next;
        cur_reg <= cur_next; ra_reg <= ra_next; t_reg <= t_next;
        ans_reg <= ans_next; da_reg <= da_next; db_reg <= db_next;
        cnt_reg <= cnt_next; side_reg <= side_next; phase_reg <= phase_next;
        sza_reg <= sza_next; od_reg <= od_next;
        stamp_a_reg <= stamp_a_next; par_a_reg <= par_a_next;
    end

    logic [TIME_W-1:0] lim;
    logic              stop;
    always_comb
    begin
        lim  = (op_reg == OP_ROOT) ? t_reg : TIME_MAX;
        stop = (rd_q.par == cur_reg) || (rd_q.stamp > lim);
    end

    always_comb
    begin
        state_next = state_reg; clr_next = clr_reg; op_next = op_reg;
        a_next = a_reg; b_next = b_reg; cur_next = cur_reg; ra_next = ra_reg;
        t_next = t_reg; now_next = now_reg; ans_next = ans_reg;
        da_next = da_reg; db_next = db_reg; cnt_next = cnt_reg;
        side_next = side_reg; phase_next = phase_reg; sza_next = sza_reg;
        ov_next = ov_reg; od_next = od_reg;
        stamp_a_next = stamp_a_reg; par_a_next = par_a_reg;
        rd_addr = cur_reg; we = 1'b0; wa = clr_reg[AW-1:0];
        wd = '{par: clr_reg[AW-1:0], size: SW'(1), stamp: '0};
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = op_t'(in_data.opcode);
                    a_next = nidx(in_data.node_a);
                    b_next = nidx(in_data.node_b);
                    t_next = in_data.at_time;
                    cur_next = nidx(in_data.node_a);
                    side_next = 1'b0; phase_next = 1'b0;
                    cnt_next = '0; ans_next = '0;
                    if (op_t'(in_data.opcode) == OP_NONE)
                    begin
                        od_next = '{value: '0, found: 1'b0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A:
            begin
                rd_addr = cur_reg;
                state_next = ST_WT_A;
            end
            ST_WT_A:
            begin
                // one chain step: root search (phase 0) or depth count (phase 1)
                if (phase_reg == 1'b0 ? stop : (rd_q.par == cur_reg))
                begin
                    if (phase_reg)
                    begin
                        if (side_reg) db_next = cnt_reg; else da_next = cnt_reg;
                        if (!side_reg)
                        begin
                            side_next = 1'b1; cnt_next = '0; cur_next = b_reg;
                            state_next = ST_RD_A;
                        end
                        else
                        begin
                            side_next = 1'b0; state_next = ST_DEPTH;
                        end
                    end
                    else if (op_reg == OP_ROOT)
                    begin
                        od_next = '{value: TIME_W'(cur_reg), found: 1'b1};
                        state_next = ST_DONE;
                    end
                    else if (!side_reg)
                    begin
                        ra_next = cur_reg; sza_next = rd_q.size;
                        side_next = 1'b1; cur_next = b_reg;
                        state_next = ST_RD_A;
                    end
                    else
                    begin
                        state_next = ST_RD_B;
                    end
                end
                else
                begin
                    cur_next = rd_q.par;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_B:
            begin
                // cur holds root of b; ra holds root of a
                if (op_reg == OP_UNITE)
                begin
                    if (now_reg != TIME_MAX) now_next = now_reg + 1'b1;
                    if (ra_reg == cur_reg)
                    begin
                        od_next = '{value: (now_reg != TIME_MAX) ? now_reg + 1'b1 : now_reg,
                                    found: 1'b0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_addr = cur_reg;
                        state_next = ST_UNITE_SZ;
                    end
                end
                else if (ra_reg != cur_reg)
                begin
                    od_next = '{value: '0, found: 1'b0};
                    state_next = ST_DONE;
                end
                else
                begin
                    phase_next = 1'b1; side_next = 1'b0; cnt_next = '0;
                    cur_next = a_reg; state_next = ST_RD_A;
                end
            end
            ST_UNITE_SZ:
            begin
                // rd_q = root b entry
                if (sza_reg < rd_q.size)
                begin
                    // b's root wins: link ra under rb
                    we = 1'b1; wa = ra_reg;
                    wd = '{par: cur_reg, size: sza_reg, stamp: now_reg};
                    sza_next = rd_q.size + sza_reg;
                    a_next = cur_reg;
                    b_next = ra_reg;
                end
                else
                begin
                    we = 1'b1; wa = cur_reg;
                    wd = '{par: ra_reg, size: rd_q.size, stamp: now_reg};
                    sza_next = sza_reg + rd_q.size;
                    a_next = ra_reg;
                    b_next = cur_reg;
                end
                state_next = ST_UNITE_WR;
            end
            ST_UNITE_WR:
            begin
                we = 1'b1; wa = a_reg;
                wd = '{par: a_reg, size: sza_reg, stamp: '0};
                od_next = '{value: now_reg, found: 1'b1};
                state_next = ST_DONE;
            end
            ST_DEPTH:
            begin
                // climb the deeper side until depths match, then walk both sides up until they meet
                if (da_reg > db_reg)
                begin
                    rd_addr = a_reg; side_next = 1'b0; state_next = ST_DEPTH_W;
                end
                else if (db_reg > da_reg)
                begin
                    rd_addr = b_reg; side_next = 1'b1; state_next = ST_DEPTH_W;
                end
                else if (a_reg == b_reg)
                begin
                    od_next = '{value: ans_reg, found: 1'b1};
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr = a_reg; state_next = ST_WALK;
                end
            end
            ST_DEPTH_W:
            begin
                if (rd_q.stamp > ans_reg) ans_next = rd_q.stamp;
                if (side_reg)
                begin
                    b_next = rd_q.par; db_next = db_reg - 1'b1;
                end
                else
                begin
                    a_next = rd_q.par; da_next = da_reg - 1'b1;
                end
                state_next = ST_DEPTH;
            end
            ST_WALK:
            begin
                // rd_q = entry a; fetch b next
                stamp_a_next = rd_q.stamp; par_a_next = rd_q.par;
                rd_addr = b_reg;
                state_next = ST_WALK_W;
            end
            ST_WALK_W:
            begin
                ans_next = ans_reg;
                if (stamp_a_reg > ans_next) ans_next = stamp_a_reg;
                if (rd_q.stamp > ans_next) ans_next = rd_q.stamp;
                a_next = par_a_reg; b_next = rd_q.par;
                state_next = ST_DEPTH;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
    `ASSERT_CLK(a_no_accept_clear, clk, rst_n, (state_reg == ST_CLEAR) |-> !in_ready, "accept during clear")
    `ASSERT_NEXT(a_root_found, clk, rst_n, state_reg == ST_DONE && op_reg == OP_ROOT && (!ov_reg || out_ready), od_reg.found, "root op without found")
endmodule
`default_nettype wire

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the persistent union-find block: directed corner requests, then
// random unite-heavy traffic, with a scoreboard that mirrors the forest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import puf_pkg::*;

    localparam int NODES = 1024;
    localparam int WATCHDOG = 20000;

    class forest_scoreboard;
        logic [NODE_W-1:0] parent [NODES];
        int unsigned       set_size [NODES];
        logic [TIME_W-1:0] stamp [NODES];
        logic [TIME_W-1:0] clock_now;
        out_item_t         pending [$];
        int                mismatches;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                parent[i] = NODE_W'(i);
                set_size[i] = 1;
                stamp[i] = '0;
            end
            clock_now = '0;
            mismatches = 0;
        endfunction

        function logic [NODE_W-1:0] root_at(logic [NODE_W-1:0] n, logic [TIME_W-1:0] t);
            for (int k = 0; k < NODES; k++)
            begin
                if (parent[n] == n || stamp[n] > t)
                    break;
                n = parent[n];
            end
            return n;
        endfunction

        function int depth_of(logic [NODE_W-1:0] n);
            int d;
            d = 0;
            while (d < NODES && parent[n] != n)
            begin
                n = parent[n];
                d++;
            end
            return d;
        endfunction

        function void note_request(in_item_t req);
            out_item_t r;
            logic [NODE_W-1:0] a, b, ra, rb, tmp;
            logic [TIME_W-1:0] ans;
            int da, db;
            a = req.node_a;
            b = req.node_b;
            r = '0;
            case (op_t'(req.opcode))
                OP_UNITE:
                begin
                    ra = root_at(a, TIME_MAX);
                    rb = root_at(b, TIME_MAX);
                    if (clock_now != TIME_MAX)
                        clock_now++;
                    if (ra != rb)
                    begin
                        if (set_size[ra] < set_size[rb])
                        begin
                            tmp = ra; ra = rb; rb = tmp;
                        end
                        parent[rb] = ra;
                        stamp[rb] = clock_now;
                        set_size[ra] += set_size[rb];
                        r.found = 1'b1;
                    end
                    r.value = clock_now;
                end
                OP_ROOT:
                begin
                    r.value = TIME_W'(root_at(a, req.at_time));
                    r.found = 1'b1;
                end
                OP_EARLIEST:
                begin
                    if (root_at(a, TIME_MAX) == root_at(b, TIME_MAX))
                    begin
                        da = depth_of(a);
                        db = depth_of(b);
                        ans = '0;
                        while (da > db)
                        begin
                            if (stamp[a] > ans) ans = stamp[a];
                            a = parent[a];
                            da--;
                        end
                        while (db > da)
                        begin
                            if (stamp[b] > ans) ans = stamp[b];
                            b = parent[b];
                            db--;
                        end
                        for (int k = 0; k < NODES && a != b; k++)
                        begin
                            if (stamp[a] > ans) ans = stamp[a];
                            if (stamp[b] > ans) ans = stamp[b];
                            a = parent[a];
                            b = parent[b];
                        end
                        r.value = ans;
                        r.found = 1'b1;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d found=%0b", got.value, got.found);
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value || got.found !== exp_r.found)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%0d found=%0b, got value=%0d found=%0b",
                             exp_r.value, exp_r.found, got.value, got.found);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    forest_scoreboard board;
    int  idle_cycles;

    persistent_union_find #(.NODES(NODES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one request transfer; gap drawn before it, valid dropped only for a gap
    task automatic send_request(in_item_t req);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(req);
    endtask

    function automatic in_item_t make_req(op_t op, int a, int b, int t);
        in_item_t r;
        r.opcode = op;
        r.node_a = NODE_W'(a);
        r.node_b = NODE_W'(b);
        r.at_time = TIME_W'(t);
        return r;
    endfunction

    // small pool keeps unites in the same trees so chains grow deep
    function automatic in_item_t random_req();
        in_item_t r;
        int pick, span;
        span = ($urandom_range(0, 9) == 0) ? 1023 : 63;
        r.node_a = NODE_W'($urandom_range(0, span));
        r.node_b = NODE_W'($urandom_range(0, span));
        r.at_time = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom())
                                                : TIME_W'($urandom_range(0, 1100));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.opcode = OP_UNITE;
        else if (pick < 70)
            r.opcode = OP_ROOT;
        else if (pick < 97)
            r.opcode = OP_EARLIEST;
        else
            r.opcode = OP_NONE;
        return r;
    endfunction

    // receiver with random stalls; ready dropped only for a stall
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_result(out_data);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_request(make_req(OP_ROOT, 0, 0, 0));
        send_request(make_req(OP_EARLIEST, 5, 5, 0));
        send_request(make_req(OP_EARLIEST, 1, 2, 0));
        send_request(make_req(OP_UNITE, 1, 2, 0));
        send_request(make_req(OP_UNITE, 2, 1, 0));
        send_request(make_req(OP_UNITE, 1023, 1022, 'hFFFFF));
        send_request(make_req(OP_UNITE, 3, 1023, 0));
        send_request(make_req(OP_UNITE, 1, 3, 0));
        send_request(make_req(OP_ROOT, 1022, 0, 0));
        send_request(make_req(OP_ROOT, 1022, 0, 3));
        send_request(make_req(OP_ROOT, 1022, 0, 'hFFFFF));
        send_request(make_req(OP_EARLIEST, 2, 1022, 0));
        send_request(make_req(OP_EARLIEST, 1022, 1023, 0));
        send_request(make_req(OP_NONE, 1023, 1023, 'hFFFFF));
        send_request(make_req(OP_NONE, 0, 0, 0));
        send_request(make_req(OP_ROOT, 1023, 1023, 'hAAAAA));
        send_request(make_req(OP_EARLIEST, 0, 1023, 'h55555));

        for (int i = 0; i < 950; i++)
            send_request(random_req());
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
